// ----- rtl/blir_pkg.sv -----
// ----------------------------------------------------------------------------
// blir_pkg
// Shared sizes, codes and helpers for the bounded list block.
// ----------------------------------------------------------------------------
package blir_pkg;

   localparam int CAPACITY   = 32;
   localparam int ADDR_W     = $clog2(CAPACITY);
   localparam int CNT_W      = $clog2(CAPACITY + 1);

   localparam int ACTION_W   = 3;
   localparam int KEY_W      = 32;
   localparam int POS_W      = 6;
   localparam int STATUS_W   = 2;
   localparam int ECNT_W     = 6;
   localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 40;

   // field offsets in the packed tdata words
   localparam int REQ_ACT_LSB  = 0;
   localparam int REQ_VAL_LSB  = REQ_ACT_LSB + ACTION_W;
   localparam int REQ_POS_LSB  = REQ_VAL_LSB + KEY_W;
   localparam int RSP_STAT_LSB = 0;
   localparam int RSP_KEY_LSB  = RSP_STAT_LSB + STATUS_W;
   localparam int RSP_CNT_LSB  = RSP_KEY_LSB + KEY_W;

   localparam logic [ACTION_W-1:0] ACT_APPEND = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_INSERT = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_REMOVE = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_DUMP   = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_CLEAR  = 3'd4;

   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd3;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [KEY_W-1:0]  wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } mem_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [KEY_W-1:0]    key;
      logic                last;
      logic [ECNT_W-1:0]   entry_count;
   } result_type;

   // physical slot of a logical index in the circular buffer
   function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] head,
                                                  input logic [ADDR_W-1:0] lg);
      logic [ADDR_W:0] sum;
      sum = {1'b0, head} + {1'b0, lg};
      if (sum >= (ADDR_W + 1)'(CAPACITY)) begin
         sum = sum - (ADDR_W + 1)'(CAPACITY);
      end
      return sum[ADDR_W-1:0];
   endfunction

endpackage

// ----- rtl/bounded_list_insert_remove.sv -----
// ----------------------------------------------------------------------------
// bounded_list_insert_remove
// Ordered list of up to CAPACITY signed keys with append, insert at front,
// remove at position, dump and clear.
// ----------------------------------------------------------------------------
// The keys sit in a single-port-write, single-port-read memory used as a
// circular buffer, so append, insert at front, clear, removal of the first or
// last entry and every error case finish without leaving the idle state.
// Removing an inner entry at position p of a list of n entries moves the tail
// down one slot per cycle through the memory. A dump first reads the head
// entry, then returns one entry per cycle while the result side keeps taking;
// a stall on the result side holds the loop. An item is taken only when the
// sequencer is idle and the output register is free or being emptied. No
// clearing pass is needed after reset.
module bounded_list_insert_remove (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // action [2:0], value [34:3], position [40:35], zero fill [47:41]
   input  logic [blir_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // status [1:0], key_out [33:2], entry_count [39:34]
   output logic [blir_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tlast
);
   import blir_pkg::*;

   mem_req_type      mem;
   logic [KEY_W-1:0] rd_data;
   logic             res_valid;
   result_type       res;
   logic             out_free;

   logic             rsp_valid_ff;
   result_type       rsp_res_ff;

   assign out_free = !rsp_valid_ff || rsp_tready;

   blir_store u_store (
      .clock   (clock),
      .mem     (mem),
      .rd_data (rd_data)
   );

   blir_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .req_action   (req_tdata[REQ_ACT_LSB +: ACTION_W]),
      .req_value    (req_tdata[REQ_VAL_LSB +: KEY_W]),
      .req_position (req_tdata[REQ_POS_LSB +: POS_W]),
      .out_free     (out_free),
      .res_valid    (res_valid),
      .res          (res),
      .mem          (mem),
      .rd_data      (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_res_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_res_ff.entry_count, rsp_res_ff.key, rsp_res_ff.status};
   assign rsp_tlast  = rsp_res_ff.last;

endmodule

// ----- rtl/blir_store.sv -----
// ----------------------------------------------------------------------------
// blir_store
// Key memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module blir_store (
   input  logic                     clock,
   input  blir_pkg::mem_req_type    mem,
   output logic [blir_pkg::KEY_W-1:0] rd_data
);
   import blir_pkg::*;

   logic [KEY_W-1:0] mem_array [CAPACITY];
   logic [KEY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem.wr_en) begin
         mem_array[mem.wr_addr] <= mem.wr_data;
      end
   end

   // read data holds while no read is issued
   always_ff @(posedge clock) begin
      if (mem.rd_en) begin
         rd_data_ff <= mem_array[mem.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/blir_ctrl.sv -----
// ----------------------------------------------------------------------------
// blir_ctrl
// List sequencer: head pointer, count, shift and dump loops over the memory.
// ----------------------------------------------------------------------------
module blir_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [blir_pkg::ACTION_W-1:0] req_action,
   input  logic [blir_pkg::KEY_W-1:0]    req_value,
   input  logic [blir_pkg::POS_W-1:0]    req_position,
   input  logic                          out_free,
   output logic                          res_valid,
   output blir_pkg::result_type          res,
   output blir_pkg::mem_req_type         mem,
   input  logic [blir_pkg::KEY_W-1:0]    rd_data
);
   import blir_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SHIFT = 3'b010,
      ST_DUMP  = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;

   logic              accept;
   logic              full;
   logic [CMP_W-1:0]  pos_c;
   logic [CMP_W-1:0]  cnt_c;
   logic [ADDR_W-1:0] idx_nxt;

   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign accept    = req_valid && req_ready;
   assign full      = (count_ff == CNT_W'(CAPACITY));
   assign pos_c     = CMP_W'(req_position);
   assign cnt_c     = CMP_W'(count_ff);
   assign idx_nxt   = idx_ff + ADDR_W'(1);

   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      mem       = '0;
      res_valid = 1'b0;
      res       = '0;
      res.last  = 1'b1;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               res_valid = 1'b1;
               case (req_action)
                  ACT_APPEND: begin
                     if (full) begin
                        res.status = STAT_FULL;
                     end else begin
                        mem.wr_en   = 1'b1;
                        mem.wr_addr = wrap_add(head_ff, ADDR_W'(count_ff));
                        mem.wr_data = req_value;
                        count_in    = count_ff + CNT_W'(1);
                     end
                  end
                  ACT_INSERT: begin
                     if (full) begin
                        res.status = STAT_FULL;
                     end else begin
                        head_in     = wrap_add(head_ff, ADDR_W'(CAPACITY - 1));
                        mem.wr_en   = 1'b1;
                        mem.wr_addr = head_in;
                        mem.wr_data = req_value;
                        count_in    = count_ff + CNT_W'(1);
                     end
                  end
                  ACT_REMOVE: begin
                     if (count_ff == '0) begin
                        res.status = STAT_EMPTY;
                     end else if (pos_c == '0 || pos_c > cnt_c) begin
                        res.status = STAT_RANGE;
                     end else if (pos_c == CMP_W'(1)) begin
                        // front entry: just move the head
                        head_in  = wrap_add(head_ff, ADDR_W'(1));
                        count_in = count_ff - CNT_W'(1);
                     end else if (pos_c == cnt_c) begin
                        count_in = count_ff - CNT_W'(1);
                     end else begin
                        // close the gap: read position, write position - 1
                        res_valid   = 1'b0;
                        mem.rd_en   = 1'b1;
                        mem.rd_addr = wrap_add(head_ff, ADDR_W'(req_position));
                        idx_in      = ADDR_W'(req_position) - ADDR_W'(1);
                        state_in    = ST_SHIFT;
                     end
                  end
                  ACT_DUMP: begin
                     if (count_ff == '0) begin
                        res.status = STAT_EMPTY;
                     end else begin
                        res_valid   = 1'b0;
                        mem.rd_en   = 1'b1;
                        mem.rd_addr = head_ff;
                        idx_in      = '0;
                        state_in    = ST_DUMP;
                     end
                  end
                  ACT_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SHIFT: begin
            mem.wr_en   = 1'b1;
            mem.wr_addr = wrap_add(head_ff, idx_ff);
            mem.wr_data = rd_data;
            if (CNT_W'(idx_ff) + CNT_W'(2) < count_ff) begin
               mem.rd_en   = 1'b1;
               mem.rd_addr = wrap_add(head_ff, idx_ff + ADDR_W'(2));
               idx_in      = idx_nxt;
            end else begin
               count_in  = count_ff - CNT_W'(1);
               res_valid = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         ST_DUMP: begin
            if (out_free) begin
               res_valid = 1'b1;
               res.key   = rd_data;
               res.last  = (CNT_W'(idx_ff) + CNT_W'(1) == count_ff);
               if (res.last) begin
                  state_in = ST_IDLE;
               end else begin
                  mem.rd_en   = 1'b1;
                  mem.rd_addr = wrap_add(head_ff, idx_nxt);
                  idx_in      = idx_nxt;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      res.entry_count = ECNT_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
   end

endmodule

// ----- rtl/blir_chk.sv -----
// ----------------------------------------------------------------------------
// blir_chk
// Port-level checks for the bounded list block, bound to the top level.
// ----------------------------------------------------------------------------
module blir_chk (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [blir_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tlast
);
   import blir_pkg::*;

   logic [STATUS_W-1:0] st;
   logic [KEY_W-1:0]    key;
   logic [ECNT_W-1:0]   cnt;

   assign st  = rsp_tdata[RSP_STAT_LSB +: STATUS_W];
   assign key = rsp_tdata[RSP_KEY_LSB +: KEY_W];
   assign cnt = rsp_tdata[RSP_CNT_LSB +: ECNT_W];

   // a stalled item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp item changed while stalled");

   // empty status only with an empty list and a single item
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && st == STAT_EMPTY |-> rsp_tlast && key == '0 && cnt == '0)
      else $error("empty status with entries or data");

   // full status only at capacity
   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && st == STAT_FULL |-> rsp_tlast && key == '0 && cnt == ECNT_W'(CAPACITY))
      else $error("full status below capacity");

   // only dump items are followed by more items of the same action
   a_dump_mid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> st == STAT_OK && cnt != '0)
      else $error("non-final item outside a dump");

   // no item is taken while a dump is still streaming
   a_no_take_mid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !(req_tvalid && req_tready))
      else $error("item taken during a dump");

endmodule

bind bounded_list_insert_remove blir_chk u_blir_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

// ----- dv/bounded_list_insert_remove_test.sv -----
// ----------------------------------------------------------------------------
// bounded_list_insert_remove_test
// Self-checking bench for the bounded list block. A queue-based model of the
// ordered key list predicts every result item at input acceptance; a monitor
// compares each result item against the oldest prediction. Directed tests
// hit empty, full and out-of-range cases, a long result-side hold backs the
// block up, and a weighted random mix grows and shrinks the list.
// ----------------------------------------------------------------------------
module bounded_list_insert_remove_test;
   import blir_pkg::*;

   localparam logic [ACTION_W-1:0] ACT_UNUSED_A = 3'd5;
   localparam logic [ACTION_W-1:0] ACT_UNUSED_C = 3'd7;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   logic [KEY_W-1:0] held_keys[$];
   result_type       expected_results[$];
   int               error_count = 0;
   bit               req_steady = 1'b0;
   bit               rsp_steady = 1'b0;
   int               hold_request = 0;

   bounded_list_insert_remove u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #4_000_000;
      $display("Some tests failed");
      $finish;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap(input bit steady);
      int roll;
      if (steady) begin
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
         return 0;
      end else if (roll < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(5, 30);
   endfunction

   function automatic void push_expected(input logic [STATUS_W-1:0] status,
                                         input logic [KEY_W-1:0] key,
                                         input logic last);
      result_type r;
      r.status      = status;
      r.key         = key;
      r.last        = last;
      r.entry_count = ECNT_W'(held_keys.size());
      expected_results.push_back(r);
   endfunction

   function automatic void predict_list_action(input logic [ACTION_W-1:0] action,
                                               input logic [KEY_W-1:0] value,
                                               input logic [POS_W-1:0] position);
      logic [STATUS_W-1:0] status;
      status = STAT_OK;
      case (action)
         ACT_APPEND: begin
            if (held_keys.size() >= CAPACITY) status = STAT_FULL;
            else held_keys.push_back(value);
         end
         ACT_INSERT: begin
            if (held_keys.size() >= CAPACITY) status = STAT_FULL;
            else held_keys.push_front(value);
         end
         ACT_REMOVE: begin
            if (held_keys.size() == 0) status = STAT_EMPTY;
            else if (position == 0 || int'(position) > held_keys.size()) status = STAT_RANGE;
            else held_keys.delete(int'(position) - 1);
         end
         ACT_DUMP: begin
            if (held_keys.size() == 0) begin
               push_expected(STAT_EMPTY, '0, 1'b1);
            end else begin
               foreach (held_keys[i]) begin
                  push_expected(STAT_OK, held_keys[i], i == held_keys.size() - 1);
               end
            end
            return;
         end
         ACT_CLEAR: held_keys.delete();
         default: ;
      endcase
      push_expected(status, '0, 1'b1);
   endfunction

   // leaves tvalid high on return so back-to-back items never toggle it
   task automatic send_item(input logic [ACTION_W-1:0] action,
                            input logic [KEY_W-1:0] value,
                            input logic [POS_W-1:0] position);
      int gap;
      gap = pick_gap(req_steady);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'b0, position, value, action};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_list_action(action, value, position);
   endtask

   function automatic logic [KEY_W-1:0] pick_key();
      logic [KEY_W-1:0] corners[4];
      corners = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
      if ($urandom_range(0, 7) == 0) begin
         return corners[2'($urandom_range(0, 3))];
      end
      return $urandom;
   endfunction

   task automatic test_basic_actions();
      send_item(ACT_DUMP, pick_key(), 6'd0);
      send_item(ACT_REMOVE, pick_key(), 6'd1);
      send_item(ACT_CLEAR, pick_key(), 6'd0);
      send_item(ACT_APPEND, 32'h7FFF_FFFF, 6'd0);
      send_item(ACT_INSERT, 32'h8000_0000, 6'd0);
      send_item(ACT_APPEND, 32'h0000_0000, 6'd0);
      send_item(ACT_APPEND, 32'hFFFF_FFFF, 6'd63);
      send_item(ACT_APPEND, 32'hA5A5_5A5A, 6'd0);
      send_item(ACT_DUMP, 32'hFFFF_FFFF, 6'd63);
      send_item(ACT_REMOVE, 32'h0, 6'd0);
      send_item(ACT_REMOVE, 32'h0, 6'd6);
      send_item(ACT_REMOVE, 32'h0, 6'd63);
      // inner, last and first entries
      send_item(ACT_REMOVE, 32'h0, 6'd3);
      send_item(ACT_REMOVE, 32'h0, 6'd4);
      send_item(ACT_REMOVE, 32'h0, 6'd1);
      send_item(ACT_DUMP, 32'h0, 6'd0);
      for (int code = ACT_UNUSED_A; code <= ACT_UNUSED_C; code++) begin
         send_item(ACTION_W'(code), 32'hFFFF_FFFF, 6'd63);
      end
      send_item(ACT_CLEAR, 32'h0, 6'd0);
      send_item(ACT_DUMP, 32'h0, 6'd0);
   endtask

   task automatic test_fill_to_capacity();
      while (held_keys.size() < CAPACITY) begin
         send_item($urandom_range(0, 1) ? ACT_APPEND : ACT_INSERT, pick_key(), 6'd0);
      end
      send_item(ACT_APPEND, pick_key(), 6'd0);
      send_item(ACT_INSERT, pick_key(), 6'd0);
      send_item(ACT_DUMP, 32'h0, 6'd0);
      send_item(ACT_REMOVE, 32'h0, 6'd33);
      send_item(ACT_REMOVE, 32'h0, 6'(CAPACITY));
      send_item(ACT_REMOVE, 32'h0, 6'd16);
      send_item(ACT_DUMP, 32'h0, 6'd0);
      send_item(ACT_CLEAR, 32'h0, 6'd0);
   endtask

   task automatic test_output_backpressure();
      req_steady   = 1'b1;
      hold_request = 300;
      for (int i = 0; i < 16; i++) begin
         send_item((i % 5 == 4) ? ACT_DUMP : ACT_APPEND, pick_key(), 6'd0);
      end
      send_item(ACT_CLEAR, 32'h0, 6'd0);
      req_steady = 1'b0;
   endtask

   task automatic test_random_mix(input int n_items, input bit steady);
      bit growing;
      growing    = 1'b1;
      req_steady = steady;
      rsp_steady = steady;
      for (int i = 0; i < n_items; i++) begin
         int                  roll;
         int                  size;
         logic [ACTION_W-1:0] action;
         logic [POS_W-1:0]    position;
         size = held_keys.size();
         if (size == 0) growing = 1'b1;
         else if (size >= CAPACITY && $urandom_range(0, 2) == 0) growing = 1'b0;
         else if ($urandom_range(0, 31) == 0) growing = !growing;
         roll     = $urandom_range(0, 99);
         position = POS_W'($urandom_range(0, 63));
         if (growing) begin
            if (roll < 35) action = ACT_APPEND;
            else if (roll < 65) action = ACT_INSERT;
            else if (roll < 82) action = ACT_REMOVE;
            else if (roll < 90) action = ACT_DUMP;
            else if (roll < 92) action = ACT_CLEAR;
            else if (roll < 95) action = ACTION_W'($urandom_range(ACT_UNUSED_A, ACT_UNUSED_C));
            else action = ACT_REMOVE;
            if (action == ACT_REMOVE && roll < 82 && size > 0) begin
               position = POS_W'($urandom_range(1, size));
            end
         end else begin
            if (roll < 10) action = ACT_APPEND;
            else if (roll < 20) action = ACT_INSERT;
            else if (roll < 85) action = ACT_REMOVE;
            else if (roll < 93) action = ACT_DUMP;
            else if (roll < 96) action = ACT_CLEAR;
            else action = ACTION_W'($urandom_range(ACT_UNUSED_A, ACT_UNUSED_C));
            if (action == ACT_REMOVE && roll < 75 && size > 0) begin
               position = POS_W'($urandom_range(1, size));
            end
         end
         send_item(action, pick_key(), position);
      end
      req_steady = 1'b0;
      rsp_steady = 1'b0;
   endtask

   initial begin : result_sink
      int stall_left;
      stall_left = 0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            stall_left   = hold_request;
            hold_request = 0;
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else if (rsp_steady) begin
            rsp_tready <= 1'b1;
         end else begin
            stall_left = pick_gap(1'b0);
            rsp_tready <= (stall_left == 0);
            if (stall_left > 0) stall_left--;
         end
      end
   end

   always @(posedge clock) begin : result_check
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            $error("result item with nothing expected: tdata %0h last %0b", rsp_tdata, rsp_tlast);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_tdata[RSP_STAT_LSB +: STATUS_W] != want.status) begin
               $error("status mismatch: expected %0d, got %0d",
                      want.status, rsp_tdata[RSP_STAT_LSB +: STATUS_W]);
               error_count++;
            end
            if (rsp_tdata[RSP_KEY_LSB +: KEY_W] != want.key) begin
               $error("key_out mismatch: expected %0h, got %0h",
                      want.key, rsp_tdata[RSP_KEY_LSB +: KEY_W]);
               error_count++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last mismatch: expected %0b, got %0b", want.last, rsp_tlast);
               error_count++;
            end
            if (rsp_tdata[RSP_CNT_LSB +: ECNT_W] != want.entry_count) begin
               $error("entry_count mismatch: expected %0d, got %0d",
                      want.entry_count, rsp_tdata[RSP_CNT_LSB +: ECNT_W]);
               error_count++;
            end
         end
      end
   end

   initial begin : test_sequence
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_basic_actions();
      test_fill_to_capacity();
      test_output_backpressure();
      test_random_mix(65, 1'b0);
      test_random_mix(27, 1'b1);
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      // catch any stray item after the last expected one
      repeat (100) @(posedge clock);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/blir_pkg.sv
rtl/blir_store.sv
rtl/blir_ctrl.sv
rtl/bounded_list_insert_remove.sv
rtl/blir_chk.sv
dv/bounded_list_insert_remove_test.sv
